/* src/heater_thermostat_safety_core_defines.svh */
// assertion macros for the heater thermostat core
`ifndef HEATER_THERMOSTAT_SAFETY_CORE_DEFINES_SVH
`define HEATER_THERMOSTAT_SAFETY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define HTSC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htsc: implication check failed");
// next-cycle implication
`define HTSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htsc: next-cycle check failed");
`else
`define HTSC_ASSERT_IMPLIES(label, ante, cons)
`define HTSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/htsc_pkg.sv */
// shared types, codes and constants of the heater thermostat core
package htsc_pkg;

	localparam int TEMP_W     = 7;
	localparam int TIME_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int TICKS_PER_SECOND_DEF = 100;

	localparam logic [TEMP_W-1:0] TEMP_MIN_RST         = 7'd20;
	localparam logic [TEMP_W-1:0] TEMP_MAX_RST         = 7'd60;
	localparam logic [TEMP_W-1:0] INIT_SETPOINT_RST    = 7'd40;
	localparam logic [TIME_W-1:0] NO_RISE_TIMEOUT_RST  = 16'd300;
	localparam logic [TIME_W-1:0] MAX_ON_TIME_RST      = 16'd600;
	localparam logic [TIME_W-1:0] REST_TIME_RST        = 16'd60;
	localparam logic [TIME_W-1:0] SESSION_LIMIT_RST    = 16'd10800;
	localparam logic [TIME_W-1:0] SHOW_TICKS_RST       = 16'd100;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_SENSOR = 2'd1,
		REQ_BUTTON = 2'd2
	} req_e;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_NO_RISE = 2'd1,
		FAULT_SESSION = 2'd2
	} fault_e;

	typedef enum logic [1:0] {
		DISP_TEMP     = 2'd0,
		DISP_SETPOINT = 2'd1,
		DISP_NO_SENSE = 2'd2
	} disp_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_MIN        = 3'd0,
		CFG_TEMP_MAX        = 3'd1,
		CFG_INIT_SETPOINT   = 3'd2,
		CFG_NO_RISE_TIMEOUT = 3'd3,
		CFG_MAX_ON_TIME     = 3'd4,
		CFG_REST_TIME       = 3'd5,
		CFG_SESSION_LIMIT   = 3'd6,
		CFG_SHOW_TICKS      = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TEMP_W-1:0] sensor_temp;
		logic              sensor_valid;
		logic              button_up;
	} in_item_t;

	typedef struct packed {
		logic              relay_on;
		logic [1:0]        fault;
		logic [1:0]        display_mode;
		logic [TEMP_W-1:0] display_value;
		logic [TEMP_W-1:0] setpoint;
	} out_item_t;

	typedef struct packed {
		logic [TEMP_W-1:0] sp_floor;
		logic [TEMP_W-1:0] sp_ceil;
		logic [TIME_W-1:0] no_rise_timeout;
		logic [TIME_W-1:0] max_on_time;
		logic [TIME_W-1:0] rest_time;
		logic [TIME_W-1:0] session_limit;
		logic [TIME_W-1:0] show_ticks;
	} cfg_t;

	// a write of the setpoint preset also loads the live setpoint
	typedef struct packed {
		logic              load;
		logic [TEMP_W-1:0] value;
	} preset_t;

endpackage

/* src/htsc_stream_if.sv */
// valid/ready stream channel carrying one payload item per transfer
interface htsc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/htsc_cfg.sv */
// configuration registers of the heater thermostat core
module htsc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [htsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [htsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output htsc_pkg::cfg_t                     cfg,
	output htsc_pkg::preset_t                  preset
);

	htsc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sp_floor        <= htsc_pkg::TEMP_MIN_RST;
			cfg_q.sp_ceil         <= htsc_pkg::TEMP_MAX_RST;
			cfg_q.no_rise_timeout <= htsc_pkg::NO_RISE_TIMEOUT_RST;
			cfg_q.max_on_time     <= htsc_pkg::MAX_ON_TIME_RST;
			cfg_q.rest_time       <= htsc_pkg::REST_TIME_RST;
			cfg_q.session_limit   <= htsc_pkg::SESSION_LIMIT_RST;
			cfg_q.show_ticks      <= htsc_pkg::SHOW_TICKS_RST;
		end else if (cfg_we) begin
			case (htsc_pkg::cfg_idx_e'(cfg_idx))
				htsc_pkg::CFG_TEMP_MIN:
					cfg_q.sp_floor <= cfg_wdata[htsc_pkg::TEMP_W-1:0];
				htsc_pkg::CFG_TEMP_MAX:
					cfg_q.sp_ceil <= cfg_wdata[htsc_pkg::TEMP_W-1:0];
				htsc_pkg::CFG_NO_RISE_TIMEOUT:
					cfg_q.no_rise_timeout <= cfg_wdata[htsc_pkg::TIME_W-1:0];
				htsc_pkg::CFG_MAX_ON_TIME:
					cfg_q.max_on_time <= cfg_wdata[htsc_pkg::TIME_W-1:0];
				htsc_pkg::CFG_REST_TIME:
					cfg_q.rest_time <= cfg_wdata[htsc_pkg::TIME_W-1:0];
				htsc_pkg::CFG_SESSION_LIMIT:
					cfg_q.session_limit <= cfg_wdata[htsc_pkg::TIME_W-1:0];
				htsc_pkg::CFG_SHOW_TICKS:
					cfg_q.show_ticks <= cfg_wdata[htsc_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// preset itself lives only in the live setpoint register of the core
	assign cfg          = cfg_q;
	assign preset.load  = cfg_we && (htsc_pkg::cfg_idx_e'(cfg_idx) == htsc_pkg::CFG_INIT_SETPOINT);
	assign preset.value = cfg_wdata[htsc_pkg::TEMP_W-1:0];

endmodule

/* src/htsc_core.sv */
// thermostat state registers and the single-pass control update
module htsc_core #(
	parameter int TICKS_PER_SECOND = htsc_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  htsc_pkg::in_item_t    item,
	input  htsc_pkg::cfg_t        cfg,
	input  htsc_pkg::preset_t     preset,
	output htsc_pkg::out_item_t   res
);

	localparam int SUB_W = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [SUB_W-1:0] SUB_WRAP = SUB_W'(TICKS_PER_SECOND);
	localparam int TW = htsc_pkg::TEMP_W;
	localparam int SW = htsc_pkg::TIME_W;

	logic [TW-1:0]    desired_q, desired_d;
	logic [TW-1:0]    last_temp_q, last_temp_d;
	logic             have_q, have_d;
	logic             relay_q, relay_d;
	htsc_pkg::fault_e fault_q, fault_d;
	logic [SW-1:0]    seconds_q, seconds_d;
	logic [SUB_W-1:0] sub_ticks_q, sub_ticks_d;
	logic [SUB_W-1:0] sub_inc;
	logic [SW-1:0]    show_count_q, show_count_d;
	logic [SW-1:0]    on_since_q, on_since_d;
	logic [SW-1:0]    check_since_q, check_since_d;
	logic [TW-1:0]    start_temp_q, start_temp_d;
	logic [SW-1:0]    rest_until_q, rest_until_d;
	logic             run_checks;

	assign sub_inc = sub_ticks_q + 1'b1;

	always_comb begin
		desired_d     = desired_q;
		last_temp_d   = last_temp_q;
		have_d        = have_q;
		relay_d       = relay_q;
		fault_d       = fault_q;
		seconds_d     = seconds_q;
		sub_ticks_d   = sub_ticks_q;
		show_count_d  = show_count_q;
		on_since_d    = on_since_q;
		check_since_d = check_since_q;
		start_temp_d  = start_temp_q;
		rest_until_d  = rest_until_q;
		run_checks    = 1'b0;

		if (fire) begin
			case (htsc_pkg::req_e'(item.req_type))
				htsc_pkg::REQ_TICK: begin
					if (show_count_q != '0)
						show_count_d = show_count_q - 1'b1;
					if (sub_inc >= SUB_WRAP) begin
						sub_ticks_d = '0;
						seconds_d   = seconds_q + 1'b1;
					end else begin
						sub_ticks_d = sub_inc;
					end
				end
				htsc_pkg::REQ_SENSOR: begin
					if (item.sensor_valid) begin
						last_temp_d = item.sensor_temp;
						have_d      = 1'b1;
					end else begin
						have_d = 1'b0;
					end
				end
				htsc_pkg::REQ_BUTTON: begin
					if (fault_q != htsc_pkg::FAULT_NONE) begin
						// press acknowledges the fault and restarts the session
						fault_d   = htsc_pkg::FAULT_NONE;
						seconds_d = '0;
					end else begin
						if (show_count_q != '0) begin
							if (!item.button_up) begin
								if (desired_q > cfg.sp_floor)
									desired_d = desired_q - 1'b1;
							end else begin
								if (desired_q < cfg.sp_ceil)
									desired_d = desired_q + 1'b1;
							end
						end
						show_count_d = cfg.show_ticks;
					end
				end
				default: begin
				end
			endcase

			// hysteresis control
			if (fault_d == htsc_pkg::FAULT_NONE) begin
				if (have_d) begin
					if ({1'b0, desired_d} > ({1'b0, last_temp_d} + (TW+1)'(1))) begin
						if (!relay_d && (seconds_d >= rest_until_d)) begin
							relay_d       = 1'b1;
							on_since_d    = seconds_d;
							check_since_d = seconds_d;
							start_temp_d  = last_temp_d;
						end
					end else if (desired_d < last_temp_d) begin
						relay_d = 1'b0;
					end
				end else begin
					relay_d = 1'b0;
				end
			end

			// both timers are checked whenever the relay was on at this point
			run_checks = relay_d;
			if (run_checks) begin
				if (SW'(seconds_d - check_since_d) >= cfg.no_rise_timeout) begin
					if (last_temp_d <= start_temp_d) begin
						relay_d = 1'b0;
						fault_d = htsc_pkg::FAULT_NO_RISE;
					end else begin
						start_temp_d  = last_temp_d;
						check_since_d = seconds_d;
					end
				end
				if (SW'(seconds_d - on_since_d) >= cfg.max_on_time) begin
					relay_d      = 1'b0;
					rest_until_d = seconds_d + cfg.rest_time;
				end
			end

			if (seconds_d >= cfg.session_limit) begin
				relay_d = 1'b0;
				fault_d = htsc_pkg::FAULT_SESSION;
			end
		end

		if (preset.load)
			desired_d = preset.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q     <= htsc_pkg::INIT_SETPOINT_RST;
			last_temp_q   <= '0;
			have_q        <= 1'b0;
			relay_q       <= 1'b0;
			fault_q       <= htsc_pkg::FAULT_NONE;
			seconds_q     <= '0;
			sub_ticks_q   <= '0;
			show_count_q  <= '0;
			on_since_q    <= '0;
			check_since_q <= '0;
			start_temp_q  <= '0;
			rest_until_q  <= '0;
		end else begin
			desired_q     <= desired_d;
			last_temp_q   <= last_temp_d;
			have_q        <= have_d;
			relay_q       <= relay_d;
			fault_q       <= fault_d;
			seconds_q     <= seconds_d;
			sub_ticks_q   <= sub_ticks_d;
			show_count_q  <= show_count_d;
			on_since_q    <= on_since_d;
			check_since_q <= check_since_d;
			start_temp_q  <= start_temp_d;
			rest_until_q  <= rest_until_d;
		end
	end

	always_comb begin
		res.relay_on = relay_d;
		res.fault    = fault_d;
		res.setpoint = desired_d;
		if (!have_d) begin
			res.display_mode  = htsc_pkg::DISP_NO_SENSE;
			res.display_value = '0;
		end else if (show_count_d != '0) begin
			res.display_mode  = htsc_pkg::DISP_SETPOINT;
			res.display_value = desired_d;
		end else begin
			res.display_mode  = htsc_pkg::DISP_TEMP;
			res.display_value = last_temp_d;
		end
	end

endmodule

/* src/heater_thermostat_safety_core.sv */
// Heater relay thermostat with no-rise, max-on-time and session safety timeouts.
// request channel: one item per transfer, a 10 ms tick, a sensor reading or a
//   button press (req_type selects which fields count).
// response channel: exactly one result per request, in order: relay drive,
//   latched fault code, display mode and value, and the current setpoint.
// cfg_we/cfg_idx/cfg_wdata write the seven setup registers and the setpoint
//   preset; write them only while no request is in flight. Writing the
//   setpoint preset also loads the live setpoint.
// A taken request waits in the input stage; it is applied when it moves on,
//   and its result is registered for response at that same clock edge.
// Throughput: one request per cycle while the response is not stalled, set by
//   the single control-update stage that reads and writes all thermostat state.
// Reset (arst_n low): setup and state registers return to their reset values,
//   the relay is off, no fault, no sensor reading, and both channels are empty.
// A stalled response holds its result; the input stage keeps one more request
//   and request.ready drops until the result is taken.
`include "heater_thermostat_safety_core_defines.svh"

module heater_thermostat_safety_core #(
	parameter int TICKS_PER_SECOND = htsc_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	htsc_stream_if.sink                      request,
	htsc_stream_if.source                    response,
	input  logic                             cfg_we,
	input  logic [htsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [htsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic                req_valid_s1;
	htsc_pkg::in_item_t  req_s1;
	logic                res_valid_q;
	htsc_pkg::out_item_t res_q;
	htsc_pkg::out_item_t core_res;
	htsc_pkg::cfg_t      cfg;
	htsc_pkg::preset_t   preset;
	logic                advance;

	// the held request moves on once the result register is free or being drained
	assign advance       = req_valid_s1 && (!res_valid_q || response.ready);
	assign request.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (request.ready) begin
			req_valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready)
			req_s1 <= request.data;
	end

	htsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg),
		.preset   (preset)
	);

	htsc_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (req_s1),
		.cfg   (cfg),
		.preset(preset),
		.res   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (response.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= core_res;
	end

	assign response.valid = res_valid_q;
	assign response.data  = res_q;

	`HTSC_ASSERT_NEXT(a_advance_gives_result, advance, res_valid_q)
	`HTSC_ASSERT_IMPLIES(a_relay_off_in_fault, res_valid_q && res_q.relay_on, res_q.fault == htsc_pkg::FAULT_NONE)
	`HTSC_ASSERT_IMPLIES(a_no_sensor_blank, res_valid_q && (res_q.display_mode == htsc_pkg::DISP_NO_SENSE), res_q.display_value == '0)

endmodule
